// ----- rtl/wtas_pkg.sv -----
// ----------------------------------------------------------------------------
// wtas_pkg: shared types and constants of the wall texel address select
// Field widths, result and face codes, register indexes and the stage-one
// record passed from the face selector to the pipeline.
// ----------------------------------------------------------------------------
package wtas_pkg;

    localparam int COORD_W  = 31;
    localparam int FRAC_W   = 16;
    localparam int TEXV_W   = 17;
    localparam int ANIM_W   = 32;
    localparam int DIM_W    = 11;
    localparam int BYTES_W  = 3;
    localparam int FCNT_W   = 6;
    localparam int FRAME_W  = 5;
    localparam int OFFS_W   = 22;
    localparam int COLOUR_W = 32;
    localparam int NUM_FACES = 4;
    localparam int SLICE_W  = 8;

    localparam logic [COLOUR_W-1:0] BG_COLOUR   = 32'h3333_3388;
    localparam logic [BYTES_W-1:0]  MAX_BYTES   = 3'd4;
    localparam logic [TEXV_W-1:0]   ONE_Q16     = 17'h1_0000;

    typedef enum logic [1:0] {
        KIND_FETCH = 2'd0,
        KIND_ZERO  = 2'd1,
        KIND_BG    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FACE_NORTH = 2'd0,
        FACE_SOUTH = 2'd1,
        FACE_EAST  = 2'd2,
        FACE_WEST  = 2'd3
    } face_t;

    typedef enum logic [2:0] {
        REG_TEX_WIDTH    = 3'd0,
        REG_TEX_HEIGHT   = 3'd1,
        REG_TEXEL_BYTES  = 3'd2,
        REG_FRAMES_NORTH = 3'd3,
        REG_FRAMES_SOUTH = 3'd4,
        REG_FRAMES_EAST  = 3'd5,
        REG_FRAMES_WEST  = 3'd6
    } reg_index_t;

    // Remainder of the frame modulo, one lane per face.
    typedef logic [FCNT_W-1:0] rem_t;
    typedef rem_t [NUM_FACES-1:0] rem_vec_t;

    typedef struct packed {
        logic                 face_ok;
        face_t                face;
        logic [TEXV_W-1:0]    u;
    } face_sel_t;

endpackage

// ----- rtl/wall_texel_address_select.sv -----
// ----------------------------------------------------------------------------
// wall_texel_address_select: texel address for one raycaster wall pixel
// Throughput: one pixel per clock while m_ready keeps the output moving; the
// five register stages (stages 1 to 4 and the output) load independently,
// so a bubble is filled even while the output is stalled.
// Reset: aresetn (synchronous, active low) empties the pipeline, restores
// the register defaults and clears the latched face frames.
// ----------------------------------------------------------------------------
module wall_texel_address_select #(
    parameter int MAX_TEX_DIM = 1024,
    parameter int MAX_FRAMES  = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_wr_en,
    input  logic [2:0]                     cfg_index,
    input  logic [wtas_pkg::DIM_W-1:0]     cfg_data,
    // Pixel input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_first_column,
    input  logic [wtas_pkg::COORD_W-1:0]   s_hit_x,
    input  logic [wtas_pkg::COORD_W-1:0]   s_hit_y,
    input  logic [wtas_pkg::COORD_W-1:0]   s_prev_hit_x,
    input  logic [wtas_pkg::COORD_W-1:0]   s_prev_hit_y,
    input  logic [wtas_pkg::COORD_W-1:0]   s_viewer_x,
    input  logic [wtas_pkg::COORD_W-1:0]   s_viewer_y,
    input  logic [wtas_pkg::TEXV_W-1:0]    s_tex_v,
    input  logic [wtas_pkg::ANIM_W-1:0]    s_anim_periods,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_result_kind,
    output logic [1:0]                     m_face,
    output logic [wtas_pkg::FRAME_W-1:0]   m_frame,
    output logic [wtas_pkg::OFFS_W-1:0]    m_byte_offset,
    output logic [wtas_pkg::COLOUR_W-1:0]  m_fixed_colour
);

    // ------------------------------------------------------------------
    // Configuration registers and their clamped working values.
    // Writes must come only while the pipeline is empty (not enforced by the
    // block), so the clamped values stay constant for any item in flight.
    // ------------------------------------------------------------------
    logic [wtas_pkg::DIM_W-1:0]   tex_width_reg;
    logic [wtas_pkg::DIM_W-1:0]   tex_height_reg;
    logic [wtas_pkg::BYTES_W-1:0] texel_bytes_reg;
    wtas_pkg::rem_vec_t           frames_cfg_reg;

    logic [wtas_pkg::DIM_W-1:0]   w_eff;
    logic [wtas_pkg::DIM_W-1:0]   h_eff;
    logic [wtas_pkg::BYTES_W-1:0] b_eff;
    wtas_pkg::rem_vec_t           n_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg     <= 11'd64;
            tex_height_reg    <= 11'd64;
            texel_bytes_reg   <= 3'd4;
            frames_cfg_reg[0] <= 6'd2;
            frames_cfg_reg[1] <= 6'd10;
            frames_cfg_reg[2] <= 6'd24;
            frames_cfg_reg[3] <= 6'd25;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wtas_pkg::REG_TEX_WIDTH:    tex_width_reg     <= cfg_data;
                wtas_pkg::REG_TEX_HEIGHT:   tex_height_reg    <= cfg_data;
                wtas_pkg::REG_TEXEL_BYTES:  texel_bytes_reg   <= cfg_data[wtas_pkg::BYTES_W-1:0];
                wtas_pkg::REG_FRAMES_NORTH: frames_cfg_reg[0] <= cfg_data[wtas_pkg::FCNT_W-1:0];
                wtas_pkg::REG_FRAMES_SOUTH: frames_cfg_reg[1] <= cfg_data[wtas_pkg::FCNT_W-1:0];
                wtas_pkg::REG_FRAMES_EAST:  frames_cfg_reg[2] <= cfg_data[wtas_pkg::FCNT_W-1:0];
                wtas_pkg::REG_FRAMES_WEST:  frames_cfg_reg[3] <= cfg_data[wtas_pkg::FCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Dimensions, bytes per texel and frame counts saturate at their limits; the clamped
    // value always fits the register width because the limit is only
    // chosen when it is below the register value.
    always_comb begin
        w_eff = (32'(tex_width_reg) > MAX_TEX_DIM)
                ? wtas_pkg::DIM_W'(MAX_TEX_DIM) : tex_width_reg;
        h_eff = (32'(tex_height_reg) > MAX_TEX_DIM)
                ? wtas_pkg::DIM_W'(MAX_TEX_DIM) : tex_height_reg;
        b_eff = (texel_bytes_reg > wtas_pkg::MAX_BYTES)
                ? wtas_pkg::MAX_BYTES : texel_bytes_reg;
        for (int k = 0; k < wtas_pkg::NUM_FACES; k++) begin
            n_eff[k] = (32'(frames_cfg_reg[k]) > MAX_FRAMES)
                       ? wtas_pkg::FCNT_W'(MAX_FRAMES) : frames_cfg_reg[k];
            // A frame count of zero behaves as one, giving frame zero.
            if (n_eff[k] == '0) begin
                n_eff[k] = wtas_pkg::FCNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control. A stage loads when it is empty or when the
    // stage after it loads, so every stage can take a new item each cycle
    // and a stall at the output only backs up as far as the bubbles allow.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic ld1, ld2, ld3, ld4, ldo;

    assign ldo     = !vo_reg || m_ready;
    assign ld4     = !v4_reg || ldo;
    assign ld3     = !v3_reg || ld4;
    assign ld2     = !v2_reg || ld3;
    assign ld1     = !v1_reg || ld2;
    assign s_ready = ld1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= s_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ldo) vo_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: face selection and the top byte of the frame modulo.
    // ------------------------------------------------------------------
    wtas_pkg::face_sel_t sel;
    wtas_pkg::rem_vec_t  rem0;

    wtas_face_select u_face_select (
        .first_column (s_first_column),
        .hit_x        (s_hit_x),
        .hit_y        (s_hit_y),
        .prev_hit_x   (s_prev_hit_x),
        .prev_hit_y   (s_prev_hit_y),
        .viewer_x     (s_viewer_x),
        .viewer_y     (s_viewer_y),
        .sel          (sel)
    );

    wtas_frame_mod u_mod_s1 (
        .rem_in  ('0),
        .bits    (s_anim_periods[31:24]),
        .divisor (n_eff),
        .rem_out (rem0)
    );

    logic                         s1_first_reg;
    logic                         s1_face_ok_reg;
    wtas_pkg::face_t              s1_face_reg;
    logic                         s1_one_reg;
    logic [wtas_pkg::FRAC_W-1:0]  s1_u_reg;
    logic [wtas_pkg::FRAC_W-1:0]  s1_v_reg;
    logic [wtas_pkg::ANIM_W-9:0]  s1_periods_reg;
    wtas_pkg::rem_vec_t           s1_rem_reg;

    always_ff @(posedge aclk) begin
        if (ld1) begin
            s1_first_reg   <= s_first_column;
            s1_face_ok_reg <= sel.face_ok;
            s1_face_reg    <= sel.face;
            // A coordinate at one or above means the zero colour.
            s1_one_reg     <= sel.u[wtas_pkg::FRAC_W] || s_tex_v[wtas_pkg::FRAC_W];
            s1_u_reg       <= sel.u[wtas_pkg::FRAC_W-1:0];
            s1_v_reg       <= s_tex_v[wtas_pkg::FRAC_W-1:0];
            s1_periods_reg <= s_anim_periods[23:0];
            s1_rem_reg     <= rem0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: texel row and column (two 11 by 16 bit products), next byte
    // of the modulo.
    // ------------------------------------------------------------------
    logic [wtas_pkg::DIM_W+wtas_pkg::FRAC_W-1:0] row_prod;
    logic [wtas_pkg::DIM_W+wtas_pkg::FRAC_W-1:0] col_prod;
    wtas_pkg::rem_vec_t                          rem1;

    assign row_prod = h_eff * s1_v_reg;
    assign col_prod = w_eff * s1_u_reg;

    wtas_frame_mod u_mod_s2 (
        .rem_in  (s1_rem_reg),
        .bits    (s1_periods_reg[23:16]),
        .divisor (n_eff),
        .rem_out (rem1)
    );

    logic                         s2_first_reg;
    logic                         s2_face_ok_reg;
    wtas_pkg::face_t              s2_face_reg;
    logic                         s2_one_reg;
    logic [wtas_pkg::DIM_W-1:0]   s2_row_reg;
    logic [wtas_pkg::DIM_W-1:0]   s2_col_reg;
    logic [15:0]                  s2_periods_reg;
    wtas_pkg::rem_vec_t           s2_rem_reg;

    always_ff @(posedge aclk) begin
        if (ld2) begin
            s2_first_reg   <= s1_first_reg;
            s2_face_ok_reg <= s1_face_ok_reg;
            s2_face_reg    <= s1_face_reg;
            s2_one_reg     <= s1_one_reg;
            s2_row_reg     <= row_prod[wtas_pkg::DIM_W+wtas_pkg::FRAC_W-1:wtas_pkg::FRAC_W];
            s2_col_reg     <= col_prod[wtas_pkg::DIM_W+wtas_pkg::FRAC_W-1:wtas_pkg::FRAC_W];
            s2_periods_reg <= s1_periods_reg[15:0];
            s2_rem_reg     <= rem1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: texel index row * width + column. The row is below the
    // height and the column below the width, so the index fits 22 bits.
    // ------------------------------------------------------------------
    logic [2*wtas_pkg::DIM_W-1:0] index_next;
    wtas_pkg::rem_vec_t           rem2;

    assign index_next = (s2_row_reg * w_eff) + {{wtas_pkg::DIM_W{1'b0}}, s2_col_reg};

    wtas_frame_mod u_mod_s3 (
        .rem_in  (s2_rem_reg),
        .bits    (s2_periods_reg[15:8]),
        .divisor (n_eff),
        .rem_out (rem2)
    );

    logic                          s3_first_reg;
    logic                          s3_face_ok_reg;
    wtas_pkg::face_t               s3_face_reg;
    logic                          s3_one_reg;
    logic [2*wtas_pkg::DIM_W-1:0]  s3_index_reg;
    logic [7:0]                    s3_periods_reg;
    wtas_pkg::rem_vec_t            s3_rem_reg;

    always_ff @(posedge aclk) begin
        if (ld3) begin
            s3_first_reg   <= s2_first_reg;
            s3_face_ok_reg <= s2_face_ok_reg;
            s3_face_reg    <= s2_face_reg;
            s3_one_reg     <= s2_one_reg;
            s3_index_reg   <= index_next;
            s3_periods_reg <= s2_periods_reg[7:0];
            s3_rem_reg     <= rem2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale by bytes per texel (kept to 22 bits), last byte of
    // the modulo.
    // ------------------------------------------------------------------
    logic [2*wtas_pkg::DIM_W+wtas_pkg::BYTES_W-1:0] bytes_prod;
    wtas_pkg::rem_vec_t                             rem3;

    assign bytes_prod = s3_index_reg * b_eff;

    wtas_frame_mod u_mod_s4 (
        .rem_in  (s3_rem_reg),
        .bits    (s3_periods_reg),
        .divisor (n_eff),
        .rem_out (rem3)
    );

    logic                          s4_first_reg;
    logic                          s4_face_ok_reg;
    wtas_pkg::face_t               s4_face_reg;
    logic                          s4_one_reg;
    logic [wtas_pkg::OFFS_W-1:0]   s4_offset_reg;
    wtas_pkg::rem_vec_t            s4_rem_reg;

    always_ff @(posedge aclk) begin
        if (ld4) begin
            s4_first_reg   <= s3_first_reg;
            s4_face_ok_reg <= s3_face_ok_reg;
            s4_face_reg    <= s3_face_reg;
            s4_one_reg     <= s3_one_reg;
            s4_offset_reg  <= bytes_prod[wtas_pkg::OFFS_W-1:0];
            s4_rem_reg     <= rem3;
        end
    end

    // ------------------------------------------------------------------
    // Output stage. A first-column pixel latches every face's frame as it
    // leaves stage 4 and uses the fresh value itself; later pixels read
    // the latched frames. Items stay in order, so this matches latching
    // at the time of the input transfer.
    // ------------------------------------------------------------------
    logic [wtas_pkg::FRAME_W-1:0]  face_frames_reg [wtas_pkg::NUM_FACES];
    logic [wtas_pkg::FRAME_W-1:0]  frame_sel;
    logic                          latch_frames;

    assign latch_frames = ldo && v4_reg && s4_first_reg;
    assign frame_sel    = s4_first_reg ? s4_rem_reg[s4_face_reg][wtas_pkg::FRAME_W-1:0]
                                       : face_frames_reg[s4_face_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < wtas_pkg::NUM_FACES; k++) begin
                face_frames_reg[k] <= '0;
            end
        end else if (latch_frames) begin
            for (int k = 0; k < wtas_pkg::NUM_FACES; k++) begin
                face_frames_reg[k] <= s4_rem_reg[k][wtas_pkg::FRAME_W-1:0];
            end
        end
    end

    logic [1:0]                    kind_reg;
    logic [1:0]                    face_reg;
    logic [wtas_pkg::FRAME_W-1:0]  frame_reg;
    logic [wtas_pkg::OFFS_W-1:0]   offset_reg;
    logic [wtas_pkg::COLOUR_W-1:0] colour_reg;

    always_ff @(posedge aclk) begin
        if (ldo) begin
            if (!s4_face_ok_reg) begin
                // No wall face: background colour, all address fields zero.
                kind_reg   <= wtas_pkg::KIND_BG;
                face_reg   <= '0;
                frame_reg  <= '0;
                offset_reg <= '0;
                colour_reg <= wtas_pkg::BG_COLOUR;
            end else if (s4_one_reg) begin
                kind_reg   <= wtas_pkg::KIND_ZERO;
                face_reg   <= s4_face_reg;
                frame_reg  <= frame_sel;
                offset_reg <= '0;
                colour_reg <= '0;
            end else begin
                kind_reg   <= wtas_pkg::KIND_FETCH;
                face_reg   <= s4_face_reg;
                frame_reg  <= frame_sel;
                offset_reg <= s4_offset_reg;
                colour_reg <= '0;
            end
        end
    end

    assign m_valid        = vo_reg;
    assign m_result_kind  = kind_reg;
    assign m_face         = face_reg;
    assign m_frame        = frame_reg;
    assign m_byte_offset  = offset_reg;
    assign m_fixed_colour = colour_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The input may only be held off when every stage holds an item.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && vo_reg))
        else $error("input stalled with a bubble in the pipeline");

    // A background result carries the background colour and no address.
    a_bg_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == wtas_pkg::KIND_BG)) |->
        ((m_fixed_colour == wtas_pkg::BG_COLOUR) && (m_byte_offset == '0)
         && (m_face == '0) && (m_frame == '0)))
        else $error("background result with non-zero address fields");

    // Only a fetch result gives a byte offset; a fetch has no colour.
    a_offset_only_on_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind != wtas_pkg::KIND_FETCH)) |-> (m_byte_offset == '0))
        else $error("non-fetch result with a byte offset");

    // Frames latched by a first-column pixel are the frames it reported.
    a_frame_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        latch_frames && s4_face_ok_reg |=> (face_frames_reg[face_reg] == frame_reg))
        else $error("latched frame differs from the reported frame");

endmodule

// ----- rtl/wtas_face_select.sv -----
// ----------------------------------------------------------------------------
// wtas_face_select: wall face and horizontal texture coordinate
// Replaces a grid-corner hit by the previous column's hit, then picks the
// face in priority order and forms the mirrored fraction u.
// ----------------------------------------------------------------------------
module wtas_face_select (
    input  logic                          first_column,
    input  logic [wtas_pkg::COORD_W-1:0]  hit_x,
    input  logic [wtas_pkg::COORD_W-1:0]  hit_y,
    input  logic [wtas_pkg::COORD_W-1:0]  prev_hit_x,
    input  logic [wtas_pkg::COORD_W-1:0]  prev_hit_y,
    input  logic [wtas_pkg::COORD_W-1:0]  viewer_x,
    input  logic [wtas_pkg::COORD_W-1:0]  viewer_y,
    output wtas_pkg::face_sel_t           sel
);

    logic                         corner;
    logic [wtas_pkg::COORD_W-1:0] hx;
    logic [wtas_pkg::COORD_W-1:0] hy;
    logic                         xgrid;
    logic                         ygrid;
    logic [wtas_pkg::TEXV_W-1:0]  frac_x;
    logic [wtas_pkg::TEXV_W-1:0]  frac_y;

    // A hit on both grid lines is ambiguous, so the previous column decides.
    assign corner = !first_column && (hit_x[wtas_pkg::FRAC_W-1:0] == '0)
                    && (hit_y[wtas_pkg::FRAC_W-1:0] == '0);
    assign hx     = corner ? prev_hit_x : hit_x;
    assign hy     = corner ? prev_hit_y : hit_y;
    assign xgrid  = (hx[wtas_pkg::FRAC_W-1:0] == '0);
    assign ygrid  = (hy[wtas_pkg::FRAC_W-1:0] == '0);
    assign frac_x = {1'b0, hx[wtas_pkg::FRAC_W-1:0]};
    assign frac_y = {1'b0, hy[wtas_pkg::FRAC_W-1:0]};

    always_comb begin
        sel.face_ok = 1'b1;
        sel.face    = wtas_pkg::FACE_NORTH;
        sel.u       = '0;
        priority if (ygrid && (hy > viewer_y)) begin
            sel.face = wtas_pkg::FACE_NORTH;
            sel.u    = wtas_pkg::ONE_Q16 - frac_x;
        end else if (ygrid && (hy < viewer_y)) begin
            sel.face = wtas_pkg::FACE_SOUTH;
            sel.u    = frac_x;
        end else if (xgrid && (hx > viewer_x)) begin
            sel.face = wtas_pkg::FACE_EAST;
            sel.u    = frac_y;
        end else if (xgrid && (hx < viewer_x)) begin
            sel.face = wtas_pkg::FACE_WEST;
            sel.u    = wtas_pkg::ONE_Q16 - frac_y;
        end else begin
            sel.face_ok = 1'b0;
        end
    end

endmodule

// ----- rtl/wtas_frame_mod.sv -----
// ----------------------------------------------------------------------------
// wtas_frame_mod: one slice of the frame-count modulo
// Restoring remainder over eight bits of the period count, four face lanes
// side by side. Each lane keeps its remainder below its frame count.
// ----------------------------------------------------------------------------
module wtas_frame_mod (
    input  wtas_pkg::rem_vec_t             rem_in,
    input  logic [wtas_pkg::SLICE_W-1:0]   bits,
    input  wtas_pkg::rem_vec_t             divisor,
    output wtas_pkg::rem_vec_t             rem_out
);

    always_comb begin
        logic [wtas_pkg::FCNT_W:0] t;
        for (int k = 0; k < wtas_pkg::NUM_FACES; k++) begin
            t = {1'b0, rem_in[k]};
            for (int i = wtas_pkg::SLICE_W - 1; i >= 0; i--) begin
                t = {t[wtas_pkg::FCNT_W-1:0], bits[i]};
                if (t >= {1'b0, divisor[k]}) begin
                    t = t - {1'b0, divisor[k]};
                end
            end
            rem_out[k] = t[wtas_pkg::FCNT_W-1:0];
        end
    end

endmodule
